// File: design/qte_pkg.sv
package qte_pkg;

  localparam int CordicStagesDefault = 16;
  localparam int AtanTableLen        = 24;

  localparam int TermW   = 34;  // Q28 products of the quaternion terms
  localparam int XyW     = 36;  // CORDIC vector width, room for gain and sign
  localparam int AngW    = 34;  // Q30 radian angle
  localparam int PitW    = 30;  // clamped asin argument
  localparam int MagW    = 29;
  localparam int SqW     = 58;  // square root remainder and partial root
  localparam int SqSteps = 29;  // one result bit per cell
  localparam int SqTopBit = 56;

  localparam logic signed [TermW-1:0] OneQ28 = 34'sd268435456;
  localparam logic signed [AngW-1:0]  PiQ30  = 34'sd3373259426;
  localparam logic [29:0] DegPerRadQ24       = 30'd961263669;

  typedef logic signed [TermW-1:0] term_t;
  typedef logic signed [AngW-1:0]  ang_t;

  typedef struct packed {
    logic [SqW-1:0]         rem;
    logic [SqW-1:0]         root;
    logic signed [PitW-1:0] pit;
    term_t                  roll_s;
    term_t                  roll_c;
    term_t                  yaw_s;
    term_t                  yaw_c;
  } sqrt_bundle_t;

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    ang_t                  z;
    logic                  zero;
  } cordic_lane_t;

  // lane 0 roll, lane 1 pitch, lane 2 yaw
  typedef cordic_lane_t [2:0] cordic_bundle_t;

  function automatic logic [29:0] atan_q30(input int idx);
    logic [29:0] v;
    unique case (idx)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      10: v = 30'd1048576;
      11: v = 30'd524288;
      12: v = 30'd262144;
      13: v = 30'd131072;
      14: v = 30'd65536;
      15: v = 30'd32768;
      16: v = 30'd16384;
      17: v = 30'd8192;
      18: v = 30'd4096;
      19: v = 30'd2048;
      20: v = 30'd1024;
      21: v = 30'd512;
      22: v = 30'd256;
      23: v = 30'd128;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/qte_sqrt_cell.sv
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int BIT_POS = 56
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  sqrt_bundle_t d_i,
  output logic         vld_o,
  output sqrt_bundle_t q_o
);

  localparam logic [SqW-1:0] Bit = SqW'(1) << BIT_POS;

  logic           vld_q;
  sqrt_bundle_t   q_q, q_d;
  logic [SqW-1:0] trial;

  // one restoring step: try root+bit against the remainder
  always_comb begin
    q_d   = d_i;
    trial = d_i.root + Bit;
    if (d_i.rem >= trial) begin
      q_d.rem  = d_i.rem - trial;
      q_d.root = (d_i.root >> 1) + Bit;
    end else begin
      q_d.root = d_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = q_q;

endmodule

// File: design/qte_cordic_cell.sv
module qte_cordic_cell import qte_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  cordic_bundle_t d_i,
  output logic           vld_o,
  output cordic_bundle_t q_o
);

  localparam ang_t Atan = AngW'(atan_q30(STAGE));

  logic           vld_q;
  cordic_bundle_t q_q, q_d;

  // vectoring rotation toward the x axis on all three lanes
  always_comb begin
    q_d = d_i;
    for (int l = 0; l < 3; l++) begin
      if (!d_i[l].y[XyW-1]) begin
        q_d[l].x = d_i[l].x + (d_i[l].y >>> STAGE);
        q_d[l].y = d_i[l].y - (d_i[l].x >>> STAGE);
        q_d[l].z = d_i[l].z + Atan;
      end else begin
        q_d[l].x = d_i[l].x - (d_i[l].y >>> STAGE);
        q_d[l].y = d_i[l].y + (d_i[l].x >>> STAGE);
        q_d[l].z = d_i[l].z - Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign vld_o = vld_q;
  assign q_o   = q_q;

endmodule

// File: design/qte_conv.sv
module qte_conv import qte_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic            deg_i,
  input  ang_t [2:0]      ang_i,
  output logic            vld_o,
  output logic [47:0]     res_o
);

  localparam logic signed [47:0] KDeg = 48'($signed({1'b0, DegPerRadQ24}));
  localparam logic signed [65:0] HalfLsb = 66'sd1 <<< 46;

  logic                     vld_a_q, vld_b_q;
  logic signed [17:0]       rad_q [3];
  logic signed [47:0]       phi_q [3];
  logic [46:0]              plo_q [3];
  logic [47:0]              res_q, res_d;
  logic signed [34:0]       rad_sum [3];
  logic signed [65:0]       deg_sum [3];
  logic signed [18:0]       deg_v [3];
  logic signed [18:0]       pick [3];

  // register the two partial products of ang * 180/pi apart
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rad_sum[l] = 35'(ang_i[l]) + 35'sd65536;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        rad_q[l] <= rad_sum[l][34:17];
        phi_q[l] <= 48'($signed(ang_i[l][AngW-1:17])) * KDeg;
        plo_q[l] <= 47'(ang_i[l][16:0]) * 47'(DegPerRadQ24);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      deg_sum[l] = (66'(phi_q[l]) <<< 17) + 66'($signed({1'b0, plo_q[l]})) + HalfLsb;
      deg_v[l]   = deg_sum[l][65:47];
      pick[l]    = deg_i ? deg_v[l] : 19'(rad_q[l]);
      if (pick[l] > 19'sd32767) begin
        res_d[16*l +: 16] = 16'h7fff;
      end else if (pick[l] < -19'sd32768) begin
        res_d[16*l +: 16] = 16'h8000;
      end else begin
        res_d[16*l +: 16] = pick[l][15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign vld_o = vld_b_q;
  assign res_o = res_q;

endmodule

// File: design/quaternion_to_euler_top.sv
// Quaternion to ZYX Euler angles. Each transaction on the slave stream carries
// one Q2.14 quaternion and yields exactly one transaction of roll, pitch and
// yaw on the master stream, in Q3.13 radians or, with the configuration bit
// set, Q9.7 degrees, saturated to 16 bits. The block is a fully pipelined
// chain of cells and accepts one quaternion every cycle while the master side
// does not stall. The chain holds 3 front stages for products, terms and the
// square of the pitch term, 29 square-root cells at one root bit each, one
// CORDIC setup stage, CORDIC_STAGES rotation cells, and the unit conversion
// with its product register and the output register. A stall on the master side
// freezes the whole chain and drops s_axis_tready_o. Write the unit bit only
// while the pipeline is empty.
module quaternion_to_euler_top import qte_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // roll, pitch, yaw
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_wdata_i        // output_in_degrees
);

  logic deg_q;
  logic en;

  // advance everything unless a result is stuck at the output
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q <= 1'b0;
    end else if (cfg_we_i) begin
      deg_q <= cfg_wdata_i[0];
    end
  end

  // ---- stage 0: the nine pairwise products the terms need
  logic signed [15:0] qw, qx, qy, qz;
  assign qw = $signed(s_axis_tdata_i[15:0]);
  assign qx = $signed(s_axis_tdata_i[31:16]);
  assign qy = $signed(s_axis_tdata_i[47:32]);
  assign qz = $signed(s_axis_tdata_i[63:48]);

  logic s0_vld_q;
  logic signed [31:0] p_xx_q, p_yy_q, p_zz_q, p_xy_q, p_wz_q, p_xz_q, p_wy_q, p_yz_q, p_wx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_xx_q <= qx * qx;
      p_yy_q <= qy * qy;
      p_zz_q <= qz * qz;
      p_xy_q <= qx * qy;
      p_wz_q <= qw * qz;
      p_xz_q <= qx * qz;
      p_wy_q <= qw * qy;
      p_yz_q <= qy * qz;
      p_wx_q <= qw * qx;
    end
  end

  // ---- stage 1: the five Q28 terms, asin argument clamped to [-1, 1]
  logic signed [35:0] roll_c_w, roll_s_w, yaw_c_w, yaw_s_w, pit_w;
  logic signed [PitW-1:0] pit_d;

  always_comb begin
    roll_s_w = (36'(p_yz_q) + 36'(p_wx_q)) <<< 1;
    roll_c_w = 36'(OneQ28) - ((36'(p_xx_q) + 36'(p_yy_q)) <<< 1);
    yaw_s_w  = (36'(p_xy_q) + 36'(p_wz_q)) <<< 1;
    yaw_c_w  = 36'(OneQ28) - ((36'(p_yy_q) + 36'(p_zz_q)) <<< 1);
    pit_w    = -((36'(p_xz_q) - 36'(p_wy_q)) <<< 1);
    if (pit_w > 36'(OneQ28)) begin
      pit_d = PitW'(OneQ28);
    end else if (pit_w < -36'(OneQ28)) begin
      pit_d = -PitW'(OneQ28);
    end else begin
      pit_d = PitW'(pit_w);
    end
  end

  logic s1_vld_q;
  term_t s1_roll_s_q, s1_roll_c_q, s1_yaw_s_q, s1_yaw_c_q;
  logic signed [PitW-1:0] s1_pit_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_roll_s_q <= TermW'(roll_s_w);
      s1_roll_c_q <= TermW'(roll_c_w);
      s1_yaw_s_q  <= TermW'(yaw_s_w);
      s1_yaw_c_q  <= TermW'(yaw_c_w);
      s1_pit_q    <= pit_d;
    end
  end

  // ---- stage 2: square of the asin argument
  logic [MagW-1:0] mag;
  assign mag = s1_pit_q[PitW-1] ? MagW'(-s1_pit_q) : MagW'(s1_pit_q);

  logic s2_vld_q;
  logic [SqW-1:0] s2_sq_q;
  term_t s2_roll_s_q, s2_roll_c_q, s2_yaw_s_q, s2_yaw_c_q;
  logic signed [PitW-1:0] s2_pit_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sq_q     <= SqW'(mag) * SqW'(mag);
      s2_roll_s_q <= s1_roll_s_q;
      s2_roll_c_q <= s1_roll_c_q;
      s2_yaw_s_q  <= s1_yaw_s_q;
      s2_yaw_c_q  <= s1_yaw_c_q;
      s2_pit_q    <= s1_pit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= s_axis_tvalid_i;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
    end
  end

  // ---- square-root chain: sqrt(1 - t^2) in Q28, roll and yaw ride along
  sqrt_bundle_t sq_bus [SqSteps+1];
  logic         sq_vld [SqSteps+1];

  always_comb begin
    sq_bus[0].rem    = (SqW'(1) << SqTopBit) - s2_sq_q;
    sq_bus[0].root   = '0;
    sq_bus[0].pit    = s2_pit_q;
    sq_bus[0].roll_s = s2_roll_s_q;
    sq_bus[0].roll_c = s2_roll_c_q;
    sq_bus[0].yaw_s  = s2_yaw_s_q;
    sq_bus[0].yaw_c  = s2_yaw_c_q;
  end
  assign sq_vld[0] = s2_vld_q;

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    qte_sqrt_cell #(
      .BIT_POS(SqTopBit - 2 * k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (sq_vld[k]),
      .d_i   (sq_bus[k]),
      .vld_o (sq_vld[k+1]),
      .q_o   (sq_bus[k+1])
    );
  end

  // ---- CORDIC setup: fold the left half-plane, flag the zero vector
  sqrt_bundle_t   sq_out;
  cordic_bundle_t prep_d, prep_q;
  logic           prep_vld_q;
  logic signed [XyW-1:0] px [3];
  logic signed [XyW-1:0] py [3];

  assign sq_out = sq_bus[SqSteps];

  always_comb begin
    px[0] = XyW'(sq_out.roll_c);
    py[0] = XyW'(sq_out.roll_s);
    px[1] = $signed({1'b0, sq_out.root[XyW-2:0]});
    py[1] = XyW'(sq_out.pit);
    px[2] = XyW'(sq_out.yaw_c);
    py[2] = XyW'(sq_out.yaw_s);
    for (int l = 0; l < 3; l++) begin
      prep_d[l].zero = (px[l] == '0) && (py[l] == '0);
      if (px[l][XyW-1]) begin
        prep_d[l].x = -px[l];
        prep_d[l].y = -py[l];
        prep_d[l].z = py[l][XyW-1] ? -PiQ30 : PiQ30;
      end else begin
        prep_d[l].x = px[l];
        prep_d[l].y = py[l];
        prep_d[l].z = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else if (en) begin
      prep_vld_q <= sq_vld[SqSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  // ---- rotation cells
  cordic_bundle_t cd_bus [CORDIC_STAGES+1];
  logic           cd_vld [CORDIC_STAGES+1];

  assign cd_bus[0] = prep_q;
  assign cd_vld[0] = prep_vld_q;

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
    qte_cordic_cell #(
      .STAGE(s)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .vld_i (cd_vld[s]),
      .d_i   (cd_bus[s]),
      .vld_o (cd_vld[s+1]),
      .q_o   (cd_bus[s+1])
    );
  end

  // ---- unit conversion and output register; atan2(0,0) forced to zero
  ang_t [2:0] ang;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ang[l] = cd_bus[CORDIC_STAGES][l].zero ? '0 : cd_bus[CORDIC_STAGES][l].z;
    end
  end

  qte_conv u_conv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (cd_vld[CORDIC_STAGES]),
    .deg_i (deg_q),
    .ang_i (ang),
    .vld_o (m_axis_tvalid_o),
    .res_o (m_axis_tdata_o)
  );

endmodule
